[rtl/gdc_pkg.sv]
`default_nettype none

package gdc_pkg;

  // largest year that passes the range check
  localparam int unsigned MAX_YEAR = 9999;

  // operand width of the shared divide unit
  localparam int unsigned OPW = 16;

  // reciprocal constants, exact for operands below 43690
  localparam logic [OPW-1:0] RECIP_100 = 16'd5243;
  localparam int unsigned    SHIFT_100 = 19;
  localparam logic [OPW-1:0] RECIP_7   = 16'd37450;
  localparam int unsigned    SHIFT_7   = 18;

  typedef struct packed {
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
  } gdc_in_t;

  typedef struct packed {
    logic        date_replaced;
    logic [4:0]  month_length;
    logic        day_fits;
    logic [21:0] day_number;
    logic [2:0]  weekday;
    logic [8:0]  days_to_friday13;
  } gdc_out_t;

  typedef enum logic {
    DIV_BY_100,
    DIV_BY_7
  } gdc_div_op_e;

  typedef struct packed {
    gdc_div_op_e    op;
    logic [OPW-1:0] operand;
  } gdc_div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WD,
    ST_WD_CAP,
    ST_W13_CAP,
    ST_SEARCH,
    ST_DONE
  } gdc_state_e;

  // days in month m, zero for month 0 and anything past december
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // common-year days in the months before m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // 31*m/12 with march counted as month one, jan and feb as 11 and 12
  function automatic logic [5:0] march_offset(input logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd0:    r = 6'd25;
      4'd1:    r = 6'd28;
      4'd2:    r = 6'd31;
      4'd3:    r = 6'd2;
      4'd4:    r = 6'd5;
      4'd5:    r = 6'd7;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd12;
      4'd8:    r = 6'd15;
      4'd9:    r = 6'd18;
      4'd10:   r = 6'd20;
      4'd11:   r = 6'd23;
      4'd12:   r = 6'd25;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // weekday advance from this month's 13th to the next month's 13th
  // month 0 is weighed as the december before january
  function automatic logic [2:0] step13(input logic [3:0] m, input logic leap);
    logic [2:0] s;
    if (m == 4'd0) begin
      s = 3'd3;
    end else begin
      case (month_len(m, leap))
        5'd29:   s = 3'd1;
        5'd30:   s = 3'd2;
        5'd31:   s = 3'd3;
        default: s = 3'd0;
      endcase
    end
    return s;
  endfunction

  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

endpackage

`default_nettype wire

[rtl/gdc_div_unit.sv]
`default_nettype none

// shared divide by a constant: reciprocal multiply, quotient registered
module gdc_div_unit (
  input  wire logic                      clk_i,
  input  wire gdc_pkg::gdc_div_req_t     req_i,
  output logic [gdc_pkg::OPW-1:0]        quot_o
);

  logic [2*gdc_pkg::OPW-1:0] prod;
  logic [gdc_pkg::OPW-1:0]   quot_d;
  logic [gdc_pkg::OPW-1:0]   quot_q;

  always_comb begin
    case (req_i.op)
      gdc_pkg::DIV_BY_100: begin
        prod   = req_i.operand * gdc_pkg::RECIP_100;
        quot_d = gdc_pkg::OPW'(prod >> gdc_pkg::SHIFT_100);
      end
      gdc_pkg::DIV_BY_7: begin
        prod   = req_i.operand * gdc_pkg::RECIP_7;
        quot_d = gdc_pkg::OPW'(prod >> gdc_pkg::SHIFT_7);
      end
      default: begin
        prod   = '0;
        quot_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/gregorian_date_calculator.sv]
`default_nettype none

// channel | direction | handshake                | payload
// --------+-----------+--------------------------+----------------------------
// in      | input     | in_valid_i / in_stall_o  | in_req_i  (day, month, year)
// out     | output    | out_valid_o / out_stall_i| out_req_o (six result fields)
//
// one request runs the divide-by-100 passes over four years, then the weekday and
// the weekday of the 13th, then the friday search over 1 to 14 months, then the
// load of the output register, which waits while a held result is stalled
// in_stall_o is high from acceptance until the result sits in the output register
// a stalled result holds in the output register while the next request is taken
// reset clears the sequencer and the output valid, no payload register is reset
module gregorian_date_calculator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire gdc_pkg::gdc_in_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output gdc_pkg::gdc_out_t     out_req_o
);

  gdc_pkg::gdc_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;

  // date in use, after the range check
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic        repl_q, repl_d;

  // quotient by 100 and divisibility by 100 of year-1 .. year+2
  logic [7:0]  q_q [4];
  logic [7:0]  q_d [4];
  logic [3:0]  ex_q, ex_d;
  logic [3:0]  leap;

  logic [2:0]  wd_q, wd_d;
  logic [21:0] dnum_q, dnum_d;

  // friday search: weekday of the 13th, day sum, month and year index
  logic [2:0]  w_q, w_d;
  logic [9:0]  sum_q, sum_d;
  logic [3:0]  sm_q, sm_d;
  logic [1:0]  sidx_q, sidx_d;

  gdc_pkg::gdc_out_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  gdc_pkg::gdc_div_req_t       div_req;
  logic [gdc_pkg::OPW-1:0]     div_quot;

  logic        in_take;
  logic        bad_date;
  logic [1:0]  cap_idx;
  logic [15:0] cap_year;
  logic        early;       // january, february or month 0
  logic [15:0] yp;          // year the weekday and leap count run on
  logic [7:0]  qp;
  logic [15:0] leap_cnt;
  logic [15:0] wd_total;
  logic [15:0] op13_next, op13;
  logic [23:0] dbase;
  logic [4:0]  cur_len;
  logic [4:0]  s_len;
  logic [10:0] dist_s;
  logic [10:0] dist_a;

  gdc_div_unit u_div (
    .clk_i  (clk_i),
    .req_i  (div_req),
    .quot_o (div_quot)
  );

  function automatic logic [15:0] year_at(input logic [13:0] y, input logic [1:0] idx);
    return {2'b00, y} - 16'd1 + {14'd0, idx};
  endfunction

  assign in_stall_o = (state_q != gdc_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  assign bad_date = (in_req_i.month_in > 4'd12) || (in_req_i.year_in == 14'd0) ||
                    ({2'b00, in_req_i.year_in} > 16'(gdc_pkg::MAX_YEAR));

  // leap flags for the four years around the date
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [15:0] yv;
      yv      = year_at(year_q, 2'(i));
      leap[i] = ((yv[1:0] == 2'b00) && !ex_q[i]) || (ex_q[i] && (q_q[i][1:0] == 2'b00));
    end
  end

  // weekday sum and leap-day count share the shifted year
  assign early    = (month_q < 4'd3);
  assign yp       = early ? year_at(year_q, 2'd0) : year_at(year_q, 2'd1);
  assign qp       = early ? q_q[0] : q_q[1];
  assign leap_cnt = (yp >> 2) - {8'd0, qp} + {10'd0, qp[7:2]};
  assign wd_total = {11'd0, day_q} + {10'd0, gdc_pkg::march_offset(month_q)} + yp + leap_cnt;
  assign dbase    = {10'd0, year_q} * 24'd365 + {19'd0, day_q} +
                    {15'd0, gdc_pkg::days_before(month_q)} + {8'd0, leap_cnt};

  assign cap_idx  = 2'(cnt_q - 3'd1);
  assign cap_year = year_at(year_q, cap_idx);
  assign cur_len  = gdc_pkg::month_len(month_q, leap[1]);
  assign s_len    = gdc_pkg::month_len(sm_q, leap[sidx_q]);
  assign op13     = {13'd0, wd_q} + 16'd34 - {11'd0, day_q};

  // distance is reported by magnitude, month 0 can make it negative
  assign dist_s   = {1'b0, sum_q} + 11'd13 - {6'd0, day_q};
  assign dist_a   = dist_s[10] ? (11'd0 - dist_s) : dist_s;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    repl_d      = repl_q;
    ex_d        = ex_q;
    wd_d        = wd_q;
    dnum_d      = dnum_q;
    w_d         = w_q;
    sum_d       = sum_q;
    sm_d        = sm_q;
    sidx_d      = sidx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    op13_next   = op13;
    for (int i = 0; i < 4; i++) begin
      q_d[i] = q_q[i];
    end
    div_req.op      = gdc_pkg::DIV_BY_100;
    div_req.operand = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      gdc_pkg::ST_IDLE: begin
        if (in_take) begin
          if (bad_date) begin
            day_d   = 5'd1;
            month_d = 4'd1;
            year_d  = 14'd1;
          end else begin
            day_d   = in_req_i.day_in;
            month_d = in_req_i.month_in;
            year_d  = in_req_i.year_in;
          end
          repl_d  = bad_date;
          cnt_d   = 3'd0;
          state_d = gdc_pkg::ST_DIV;
        end
      end

      // issue year-1+cnt, capture the quotient issued in the previous cycle
      gdc_pkg::ST_DIV: begin
        div_req.op      = gdc_pkg::DIV_BY_100;
        div_req.operand = year_at(year_q, cnt_q[1:0]);
        if (cnt_q != 3'd0) begin
          q_d[cap_idx]  = div_quot[7:0];
          ex_d[cap_idx] = (div_quot * 16'd100) == cap_year;
        end
        if (cnt_q == 3'd4) begin
          state_d = gdc_pkg::ST_WD;
        end
        cnt_d = cnt_q + 3'd1;
      end

      gdc_pkg::ST_WD: begin
        div_req.op      = gdc_pkg::DIV_BY_7;
        div_req.operand = wd_total;
        state_d         = gdc_pkg::ST_WD_CAP;
      end

      gdc_pkg::ST_WD_CAP: begin
        wd_d = 3'(wd_total - div_quot * 16'd7);
        if (dbase < 24'd366) begin
          dnum_d = '0;
        end else begin
          dnum_d = 22'(dbase - 24'd366);
        end
        // weekday of this month's 13th
        op13_next       = {13'd0, wd_d} + 16'd34 - {11'd0, day_q};
        div_req.op      = gdc_pkg::DIV_BY_7;
        div_req.operand = op13_next;
        state_d         = gdc_pkg::ST_W13_CAP;
      end

      gdc_pkg::ST_W13_CAP: begin
        w_d    = 3'(op13 - div_quot * 16'd7);
        sidx_d = 2'd1;
        if (day_q > 5'd13) begin
          // this month's 13th is past, start with the next month
          sum_d = {5'd0, cur_len};
          w_d   = gdc_pkg::add_mod7(w_d, gdc_pkg::step13(month_q, leap[1]));
          if (month_q >= 4'd12) begin
            sm_d   = 4'd1;
            sidx_d = 2'd2;
          end else begin
            sm_d = month_q + 4'd1;
          end
        end else begin
          sum_d = '0;
          sm_d  = month_q;
        end
        state_d = gdc_pkg::ST_SEARCH;
      end

      gdc_pkg::ST_SEARCH: begin
        if (w_q == 3'd5) begin
          state_d = gdc_pkg::ST_DONE;
        end else begin
          sum_d = sum_q + {5'd0, s_len};
          w_d   = gdc_pkg::add_mod7(w_q, gdc_pkg::step13(sm_q, leap[sidx_q]));
          if (sm_q >= 4'd12) begin
            sm_d = 4'd1;
            if (sidx_q != 2'd3) begin
              sidx_d = sidx_q + 2'd1;
            end
          end else begin
            sm_d = sm_q + 4'd1;
          end
        end
      end

      gdc_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.date_replaced    = repl_q;
          out_d.month_length     = cur_len;
          out_d.day_fits         = (day_q <= cur_len);
          out_d.day_number       = dnum_q;
          out_d.weekday          = wd_q;
          out_d.days_to_friday13 = dist_a[8:0];
          out_valid_d            = 1'b1;
          state_d                = gdc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = gdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    repl_q  <= repl_d;
    ex_q    <= ex_d;
    wd_q    <= wd_d;
    dnum_q  <= dnum_d;
    w_q     <= w_d;
    sum_q   <= sum_d;
    sm_q    <= sm_d;
    sidx_q  <= sidx_d;
    out_q   <= out_d;
    for (int i = 0; i < 4; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire
